FILE: rtl/core/edp_pkg.sv
package edp_pkg;

  localparam int unsigned CfgIndexW = 3;
  localparam int unsigned CfgDataW  = 16;
  localparam int unsigned PosW      = 16;
  localparam int unsigned TicksW    = 16;
  localparam int unsigned DeadbandW = 8;
  localparam int unsigned InDataW   = 8;
  localparam int unsigned OutDataW  = 24;

  localparam logic [CfgIndexW-1:0] CFG_TARGET_POSITION = 3'd0;
  localparam logic [CfgIndexW-1:0] CFG_DEADBAND        = 3'd1;
  localparam logic [CfgIndexW-1:0] CFG_ON_TICKS        = 3'd2;
  localparam logic [CfgIndexW-1:0] CFG_PERIOD_TICKS    = 3'd3;
  localparam logic [CfgIndexW-1:0] CFG_COUNT_REVERSE   = 3'd4;

  localparam logic signed [PosW-1:0] RST_TARGET_POSITION = 16'sd0;
  localparam logic [DeadbandW-1:0]   RST_DEADBAND        = 8'd1;
  localparam logic [TicksW-1:0]      RST_ON_TICKS        = 16'd250;
  localparam logic [TicksW-1:0]      RST_PERIOD_TICKS    = 16'd1000;

  localparam logic signed [PosW-1:0] POS_MAX = 16'sh7FFF;
  localparam logic signed [PosW-1:0] POS_MIN = 16'sh8000;

  typedef enum logic [1:0] {
    DIR_IDLE    = 2'd0,
    DIR_FORWARD = 2'd1,
    DIR_REVERSE = 2'd2
  } dir_t;

  typedef struct packed {
    logic signed [PosW-1:0] target_position;
    logic [DeadbandW-1:0]   deadband;
    logic [TicksW-1:0]      on_ticks;
    logic [TicksW-1:0]      period_ticks;
    logic                   count_reverse;
  } cfg_t;

  typedef struct packed {
    logic                   settled;
    logic signed [PosW-1:0] position;
    logic                   drive_reverse;
    logic                   drive_forward;
  } res_t;

endpackage

FILE: rtl/core/edp_cfg.sv
module edp_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [edp_pkg::CfgIndexW-1:0]    cfg_index,
  input  logic [edp_pkg::CfgDataW-1:0]     cfg_wdata,
  output edp_pkg::cfg_t                    cfg
);

  edp_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.target_position <= edp_pkg::RST_TARGET_POSITION;
      cfg_r.deadband        <= edp_pkg::RST_DEADBAND;
      cfg_r.on_ticks        <= edp_pkg::RST_ON_TICKS;
      cfg_r.period_ticks    <= edp_pkg::RST_PERIOD_TICKS;
      cfg_r.count_reverse   <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        edp_pkg::CFG_TARGET_POSITION: cfg_r.target_position <= cfg_wdata;
        edp_pkg::CFG_DEADBAND:        cfg_r.deadband <= cfg_wdata[edp_pkg::DeadbandW-1:0];
        edp_pkg::CFG_ON_TICKS:        cfg_r.on_ticks <= cfg_wdata;
        edp_pkg::CFG_PERIOD_TICKS:    cfg_r.period_ticks <= cfg_wdata;
        edp_pkg::CFG_COUNT_REVERSE:   cfg_r.count_reverse <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

FILE: rtl/core/edp_core.sv
module edp_core (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          step,
  input  logic          enc_a,
  input  logic          enc_b,
  input  edp_pkg::cfg_t cfg,
  output edp_pkg::res_t res
);

  logic signed [edp_pkg::PosW-1:0] count_r, count_nxt;
  logic                            prev_a_r;
  logic [edp_pkg::TicksW-1:0]      phase_r, phase_nxt;
  edp_pkg::dir_t                   dir_r, dir_nxt;

  logic                            up;
  logic signed [edp_pkg::PosW+1:0] pos_w, low_w, high_w;
  logic                            below, above;
  logic [edp_pkg::TicksW-1:0]      period;
  logic [edp_pkg::TicksW:0]        phase_inc;
  logic                            drive_on;

  always_comb begin
    up = enc_b ^ cfg.count_reverse;
    count_nxt = count_r;
    if (!prev_a_r && enc_a) begin
      if (up) begin
        if (count_r != edp_pkg::POS_MAX) count_nxt = count_r + 16'sd1;
      end else begin
        if (count_r != edp_pkg::POS_MIN) count_nxt = count_r - 16'sd1;
      end
    end
  end

  // Window bounds carry two extra bits so target +/- deadband never wraps.
  always_comb begin
    pos_w  = {{2{count_nxt[edp_pkg::PosW-1]}}, count_nxt};
    low_w  = {{2{cfg.target_position[edp_pkg::PosW-1]}}, cfg.target_position}
             - $signed({10'd0, cfg.deadband});
    high_w = {{2{cfg.target_position[edp_pkg::PosW-1]}}, cfg.target_position}
             + $signed({10'd0, cfg.deadband});
    below  = pos_w < low_w;
    above  = pos_w > high_w;
  end

  always_comb begin
    dir_nxt = dir_r;
    if (phase_r == '0) begin
      if (below) begin
        dir_nxt = edp_pkg::DIR_FORWARD;
      end else if (above) begin
        dir_nxt = edp_pkg::DIR_REVERSE;
      end else begin
        dir_nxt = edp_pkg::DIR_IDLE;
      end
    end
  end

  always_comb begin
    period    = (cfg.period_ticks == '0) ? 16'd1 : cfg.period_ticks;
    phase_inc = {1'b0, phase_r} + 17'd1;
    phase_nxt = (phase_inc >= {1'b0, period}) ? '0 : phase_inc[edp_pkg::TicksW-1:0];
    drive_on  = phase_r < cfg.on_ticks;
  end

  always_comb begin
    res.drive_forward = drive_on && (dir_nxt == edp_pkg::DIR_FORWARD);
    res.drive_reverse = drive_on && (dir_nxt == edp_pkg::DIR_REVERSE);
    res.position      = count_nxt;
    res.settled       = !below && !above;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      prev_a_r <= 1'b0;
      phase_r  <= '0;
      dir_r    <= edp_pkg::DIR_IDLE;
    end else if (step) begin
      count_r  <= count_nxt;
      prev_a_r <= enc_a;
      phase_r  <= phase_nxt;
      dir_r    <= dir_nxt;
    end
  end

endmodule

FILE: rtl/core/encoder_deadband_positioner.sv
// Encoder deadband positioner: one axis of a quadrature-encoder bang-bang
// position controller.
// The input stream carries one beat per time tick with the sampled encoder
// lines. Every input beat produces exactly one output beat holding the
// drive lines, the position after that tick's edge update and the settled
// flag. Settings are to be written through the cfg_ port only while the block
// is idle; the block itself does not enforce this. An accepted beat sits in
// the input register, then the edge update, window compare and drive-period
// logic run in a single pass into the output register, which drives out_tvalid.
// Throughput is one beat per cycle while out_tready stays high; the single-pass
// logic between the two registers and the one-tick state update set that figure.
// Reset (rst_n low, synchronous) clears the position, the last A level, the
// period phase and the drive direction, empties both registers and restores
// the register defaults (target 0, deadband 1, on 250, period 1000).
// When the receiver stalls, the output beat is held; an empty input register
// still takes one more beat, then in_tready drops until the output moves.
module encoder_deadband_positioner (
  input  logic                          clk,
  input  logic                          rst_n,
  // Input channel. tdata: [0] enc_a, [1] enc_b, [7:2] zero.
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [edp_pkg::InDataW-1:0]   in_tdata,
  // Output channel. tdata: [0] drive_forward, [1] drive_reverse,
  // [17:2] position, [18] settled, [23:19] zero.
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [edp_pkg::OutDataW-1:0]  out_tdata,
  // Configuration write port.
  input  logic                          cfg_we,
  input  logic [edp_pkg::CfgIndexW-1:0] cfg_index,
  input  logic [edp_pkg::CfgDataW-1:0]  cfg_wdata
);

  edp_pkg::cfg_t cfg;
  edp_pkg::res_t res;

  // Input register stage.
  logic a_valid_r;
  logic a_enc_a_r;
  logic a_enc_b_r;

  // Output register stage.
  logic          out_valid_r;
  edp_pkg::res_t out_res_r;

  logic advance;
  logic step;

  // The input register moves forward whenever the output register is
  // empty or its beat is being taken in this cycle.
  assign advance   = !out_valid_r || out_tready;
  assign step      = a_valid_r && advance;
  assign in_tready = !a_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (in_tready) begin
      a_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      a_enc_a_r <= in_tdata[0];
      a_enc_b_r <= in_tdata[1];
    end
  end

  edp_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // Tick state advances only when an item leaves the input register, so a
  // stalled receiver never lets the count or the period phase run ahead.
  edp_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .enc_a (a_enc_a_r),
    .enc_b (a_enc_b_r),
    .cfg   (cfg),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, out_res_r};

  // Both drive lines are never asserted together.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_res_r.drive_forward && out_res_r.drive_reverse))
    else $error("both drive lines asserted");

  // Input backpressure only ever comes from a full, stalled output stage.
  assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (a_valid_r && out_valid_r && !out_tready))
    else $error("input stalled without output backpressure");

  // An output beat taken with nothing behind it leaves the output empty.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_tready && !a_valid_r) |=> !out_valid_r)
    else $error("output beat repeated");

endmodule
